/* rtl/core/mdps_pkg.sv */
// Package for the moon disk pixel shader: sizes, fixed-point constants,
// register codes, stage structs and shared helper functions.
// No dependencies.
package mdps_pkg;

    localparam int TEX_SIZE    = 64;
    localparam int MAX_RADIUS  = 255;
    localparam int TEX_HALF    = TEX_SIZE / 2;
    localparam int TEX_R       = TEX_HALF - 1;
    localparam int QW          = $clog2(TEX_HALF);
    localparam int NW          = 9 + QW;
    localparam int TXW         = QW + 2;
    localparam int IW          = 2 * QW + 4;
    localparam int STORE_DEPTH = 4096;
    localparam int AW          = 12;

    localparam logic [12:0] SHADE_UNLIT     = 13'd287;
    localparam logic [12:0] SHADE_RAMP_LOW  = 13'd3768;
    localparam logic [12:0] SHADE_FULL      = 13'd4096;
    localparam logic [12:0] SHADE_FULL_AT   = 13'd4055;
    localparam int          SHADE_RAMP_SPAN = 328;
    localparam int          EDGE_Q4         = 20;
    localparam logic [24:0] BLEND_BASE      = 25'd1175552;
    localparam logic [11:0] BLEND_GAIN      = 12'd3809;
    localparam logic [11:0] RAMP_RECIP      = 12'd3277;
    localparam int          RAMP_RECIP_SH   = 17;

    typedef enum logic [2:0] {
        CFG_RADIUS   = 3'd0,
        CFG_ILLUM    = 3'd1,
        CFG_WAXING   = 3'd2,
        CFG_CENTER_X = 3'd3,
        CFG_CENTER_Y = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  radius;
        logic [12:0] illum;
        logic        waxing;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              pixel;
        logic [AW-1:0]     tex_addr;
        logic [7:0]        tex_value;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
    } in_item_t;

    typedef struct packed {
        logic               valid;
        logic               pixel;
        logic [AW-1:0]      tex_addr;
        logic [7:0]         tex_value;
        logic               in_disk;
        logic               neg_x;
        logic               neg_y;
        logic [QW-1:0]      qx;
        logic [QW-1:0]      qy;
        logic               lit;
        logic signed [15:0] term_dist;
        logic signed [11:0] sx;
        logic signed [11:0] sy;
    } geom_t;

    function automatic logic [QW-1:0] div_q(input logic [NW-1:0] num, input logic [7:0] den);
        logic [NW-1:0]    rem;
        logic [NW+QW-1:0] sh;
        logic [QW-1:0]    q;
        rem = num;
        q   = '0;
        for (int k = QW - 1; k >= 0; k--) begin
            sh = (NW+QW)'(den) << k;
            if ((NW+QW)'(rem) >= sh) begin
                rem  = NW'((NW+QW)'(rem) - sh);
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // divide the ramp product by 2 * EDGE_Q4 through a reciprocal multiply
    function automatic logic [12:0] ramp_shade(input logic [5:0] step);
        logic [15:0] prod;
        logic [27:0] scaled;
        prod   = 16'(SHADE_RAMP_SPAN * int'(step));
        scaled = 28'(prod) * 28'(RAMP_RECIP);
        return 13'(SHADE_RAMP_LOW + 13'(scaled >> RAMP_RECIP_SH));
    endfunction

endpackage

/* rtl/core/mdps_geom.sv */
// Disk geometry stages: squares and products, then disk test, texel
// quotients and terminator distance. Depends on mdps_pkg.
module mdps_geom (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  mdps_pkg::cfg_t    cfg,
    input  mdps_pkg::in_item_t in_item,
    output mdps_pkg::geom_t   geom
);
    import mdps_pkg::*;

    in_item_t s1_reg;
    logic [7:0]  r_sat;
    logic [12:0] il_sat;

    logic [NW-1:0]      nx_next, ny_next, nx_reg, ny_reg;
    logic [17:0]        sumsq_next, sumsq_reg;
    logic [15:0]        rr_next, rr_reg;
    logic signed [23:0] t12_next, t12_reg;
    logic signed [11:0] sx_next, sy_next, sx_reg, sy_reg;
    logic               mir_next, mir_reg;
    logic               v2_reg, pix2_reg;
    logic [AW-1:0]      addr2_reg;
    logic [7:0]         val2_reg, r2_reg;
    logic signed [8:0]  dx2_reg;
    logic               negx2_reg, negy2_reg;
    geom_t              geom_next, geom_reg;

    logic [8:0]         adx, ady;
    logic signed [13:0] tfac;
    logic signed [23:0] x12;
    logic signed [15:0] t4, dx16;

    assign r_sat  = (int'(cfg.radius) > MAX_RADIUS) ? 8'(MAX_RADIUS) : cfg.radius;
    assign il_sat = (cfg.illum > 13'd4096) ? 13'd4096 : cfg.illum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_reg <= in_item;
        end
    end

    always_comb begin
        adx        = s1_reg.dx[8] ? 9'(-s1_reg.dx) : 9'(s1_reg.dx);
        ady        = s1_reg.dy[8] ? 9'(-s1_reg.dy) : 9'(s1_reg.dy);
        nx_next    = NW'(adx * TEX_R);
        ny_next    = NW'(ady * TEX_R);
        sumsq_next = 18'(adx * adx) + 18'(ady * ady);
        rr_next    = 16'(r_sat * r_sat);
        tfac       = 14'sd4096 - signed'({il_sat, 1'b0});
        t12_next   = 24'(tfac * signed'({1'b0, r_sat}));
        sx_next    = signed'({2'b00, cfg.center_x}) + 12'(s1_reg.dx);
        sy_next    = signed'({2'b00, cfg.center_y}) + 12'(s1_reg.dy);
        mir_next   = !cfg.waxing && (il_sat <= 13'd2048);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= s1_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix2_reg  <= s1_reg.pixel;
            addr2_reg <= s1_reg.tex_addr;
            val2_reg  <= s1_reg.tex_value;
            r2_reg    <= r_sat;
            dx2_reg   <= s1_reg.dx;
            negx2_reg <= s1_reg.dx[8];
            negy2_reg <= s1_reg.dy[8];
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            sumsq_reg <= sumsq_next;
            rr_reg    <= rr_next;
            t12_reg   <= t12_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            mir_reg   <= mir_next;
        end
    end

    always_comb begin
        x12  = 24'(dx2_reg) <<< 12;
        t4   = 16'(t12_reg >>> 8);
        dx16 = 16'(dx2_reg) <<< 4;
        geom_next.valid     = v2_reg;
        geom_next.pixel     = pix2_reg;
        geom_next.tex_addr  = addr2_reg;
        geom_next.tex_value = val2_reg;
        geom_next.in_disk   = (r2_reg != 8'd0) && (sumsq_reg <= 18'(rr_reg));
        geom_next.neg_x     = negx2_reg;
        geom_next.neg_y     = negy2_reg;
        geom_next.qx        = div_q(nx_reg, r2_reg);
        geom_next.qy        = div_q(ny_reg, r2_reg);
        geom_next.lit       = mir_reg ? (x12 < -t12_reg) : (x12 > t12_reg);
        geom_next.term_dist = mir_reg ? (-t4 - dx16) : (dx16 - t4);
        geom_next.sx        = sx_reg;
        geom_next.sy        = sy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg.valid <= 1'b0;
        end else if (adv) begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

/* rtl/core/mdps_shade.sv */
// Texture store, phase shade, luma blend and RGB565 packing stages.
// Depends on mdps_pkg; fed by mdps_geom.
module mdps_shade (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  mdps_pkg::geom_t     geom,
    output logic                out_valid,
    output logic                out_draw,
    output logic signed [11:0]  out_x,
    output logic signed [11:0]  out_y,
    output logic [7:0]          out_luma,
    output logic [15:0]         out_color
);
    import mdps_pkg::*;

    logic [7:0] tex_mem [STORE_DEPTH];

    logic signed [TXW-1:0] tx, ty;
    logic [IW-1:0]         idx;
    logic                  in_tex;
    logic [12:0]           shade_next;
    logic signed [15:0]    dplus;

    logic               v4_reg, pix4_reg, ok4_reg;
    logic [12:0]        shade4_reg;
    logic [7:0]         tex4_reg;
    logic signed [11:0] sx4_reg, sy4_reg;

    logic               v5_reg, pix5_reg, ok5_reg, full5_reg;
    logic [24:0]        f5_reg;
    logic [7:0]         tex5_reg;
    logic signed [11:0] sx5_reg, sy5_reg;

    logic [32:0] num;
    logic [7:0]  luma;
    logic        draw;

    logic               ov_reg, draw_reg;
    logic signed [11:0] x_reg, y_reg;
    logic [7:0]         luma_reg;
    logic [15:0]        color_reg;

    always_comb begin
        tx = TXW'(TEX_HALF) + (geom.neg_x ? -TXW'(geom.qx) : TXW'(geom.qx));
        ty = TXW'(TEX_HALF) + (geom.neg_y ? -TXW'(geom.qy) : TXW'(geom.qy));
        idx = IW'(ty[TXW-2:0] * TEX_SIZE) + IW'(tx[TXW-2:0]);
        in_tex = !tx[TXW-1] && !ty[TXW-1] && (int'(tx) < TEX_SIZE)
              && (int'(ty) < TEX_SIZE) && (int'(idx) < STORE_DEPTH);
        dplus = geom.term_dist + 16'sd20;
        if (!geom.lit) begin
            shade_next = SHADE_UNLIT;
        end else if (geom.term_dist >= 16'(EDGE_Q4)) begin
            shade_next = SHADE_FULL;
        end else if (geom.term_dist <= -16'(EDGE_Q4)) begin
            shade_next = SHADE_RAMP_LOW;
        end else begin
            shade_next = ramp_shade(dplus[5:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (geom.valid && !geom.pixel) begin
                tex_mem[geom.tex_addr] <= geom.tex_value;
            end
            tex4_reg <= tex_mem[idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= geom.valid;
            v5_reg <= v4_reg;
            ov_reg <= v5_reg && pix5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix4_reg   <= geom.pixel;
            ok4_reg    <= geom.in_disk && in_tex;
            shade4_reg <= shade_next;
            sx4_reg    <= geom.sx;
            sy4_reg    <= geom.sy;
            pix5_reg   <= pix4_reg;
            ok5_reg    <= ok4_reg;
            full5_reg  <= shade4_reg >= SHADE_FULL_AT;
            f5_reg     <= BLEND_BASE + 25'(BLEND_GAIN * shade4_reg);
            tex5_reg   <= tex4_reg;
            sx5_reg    <= sx4_reg;
            sy5_reg    <= sy4_reg;
        end
    end

    always_comb begin
        num  = (33'(tex5_reg) * 33'(f5_reg) + 33'(1 << 23)) >> 24;
        if (full5_reg) begin
            luma = tex5_reg;
        end else if (num > 33'd255) begin
            luma = 8'd255;
        end else begin
            luma = num[7:0];
        end
        draw = ok5_reg && (tex5_reg != 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            draw_reg  <= draw;
            x_reg     <= draw ? sx5_reg : 12'sd0;
            y_reg     <= draw ? sy5_reg : 12'sd0;
            luma_reg  <= draw ? luma : 8'd0;
            color_reg <= draw ? {luma[7:3], luma[7:2], luma[7:3]} : 16'd0;
        end
    end

    assign out_valid = ov_reg;
    assign out_draw  = draw_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_luma  = luma_reg;
    assign out_color = color_reg;

endmodule

/* rtl/core/moon_disk_pixel_shader.sv */
// Moon disk pixel shader top level: configuration registers, stall control,
// geometry and shading pipelines. Depends on mdps_pkg, mdps_geom, mdps_shade.
// Throughput: one item per cycle; the six-stage pipeline stalls as a whole
// while the output register holds an untaken result.
// Reset: synchronous active-low aresetn clears valid bits and loads register
// defaults; the texture store is not cleared.
module moon_disk_pixel_shader (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [11:0]        s_tex_addr,
    input  logic [7:0]         s_tex_value,
    input  logic signed [8:0]  s_dx_offset,
    input  logic signed [8:0]  s_dy_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_draw,
    output logic signed [11:0] m_screen_x,
    output logic signed [11:0] m_screen_y,
    output logic [7:0]         m_luma,
    output logic [15:0]        m_pixel_color,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [12:0]        cfg_wdata
);
    import mdps_pkg::*;

    cfg_t     cfg_reg;
    in_item_t in_item;
    geom_t    geom;
    logic     adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.radius   <= 8'd1;
            cfg_reg.illum    <= 13'd0;
            cfg_reg.waxing   <= 1'b1;
            cfg_reg.center_x <= 10'd0;
            cfg_reg.center_y <= 10'd0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_RADIUS:   cfg_reg.radius   <= cfg_wdata[7:0];
                CFG_ILLUM:    cfg_reg.illum    <= cfg_wdata;
                CFG_WAXING:   cfg_reg.waxing   <= cfg_wdata[0];
                CFG_CENTER_X: cfg_reg.center_x <= cfg_wdata[9:0];
                CFG_CENTER_Y: cfg_reg.center_y <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_comb begin
        in_item.valid     = s_valid;
        in_item.pixel     = s_mode;
        in_item.tex_addr  = s_tex_addr;
        in_item.tex_value = s_tex_value;
        in_item.dx        = s_dx_offset;
        in_item.dy        = s_dy_offset;
    end

    mdps_geom u_geom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg_reg),
        .in_item (in_item),
        .geom    (geom)
    );

    mdps_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .geom      (geom),
        .out_valid (m_valid),
        .out_draw  (m_draw),
        .out_x     (m_screen_x),
        .out_y     (m_screen_y),
        .out_luma  (m_luma),
        .out_color (m_pixel_color)
    );

endmodule
